>>> rtl/sjs_pkg.sv
// ----------------------------------------------------------------------------
// sjs_pkg
// Shared types and codes of the stepper jog sequencer.
// ----------------------------------------------------------------------------
package sjs_pkg;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_IDLE_TIMEOUT    = 2'd0;
  localparam logic [1:0] REG_RELEASE_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_HYSTERESIS      = 2'd2;
  localparam logic [1:0] REG_RUN_SPEED       = 2'd3;

  // Reset values of the configuration registers
  localparam logic [15:0] IDLE_TIMEOUT_RST    = 16'd20000;
  localparam logic [15:0] RELEASE_TIMEOUT_RST = 16'd1000;
  localparam logic [7:0]  HYSTERESIS_RST      = 8'd5;
  localparam logic [14:0] RUN_SPEED_RST       = 15'd256;

  // Depth of the queue between classifier and sequencer
  localparam int QUEUE_DEPTH_DEF = 2;

  // Analog class codes
  localparam logic [1:0] CL_OPEN = 2'd0;
  localparam logic [1:0] CL_LOW  = 2'd1;
  localparam logic [1:0] CL_HIGH = 2'd2;

  // Motor command codes
  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_RUN_FWD = 3'd1;
  localparam logic [2:0] CMD_RUN_BWD = 3'd2;
  localparam logic [2:0] CMD_STOP    = 3'd3;
  localparam logic [2:0] CMD_SLEEP   = 3'd4;

  // One control pass as it arrives
  typedef struct packed {
    logic       sample_valid;
    logic [9:0] supply_level;
    logic [9:0] output_level;
    logic       stop_pressed;
    logic       forward_pressed;
    logic       backward_pressed;
    logic       front_limit;
    logic       rear_limit;
    logic [7:0] elapsed_ticks;
  } in_item_t;

  // One result of a pass
  typedef struct packed {
    logic [2:0]        motor_command;
    logic signed [15:0] drive_speed;
    logic [2:0]        sequence_state;
    logic [1:0]        analog_class;
    logic              fault_led;
  } out_item_t;

  // Classified pass handed from front to back
  typedef struct packed {
    logic       stop_pressed;
    logic       forward_pressed;
    logic       backward_pressed;
    logic       front_limit;
    logic       rear_limit;
    logic [7:0] elapsed_ticks;
    logic [1:0] level_class;
  } q_item_t;

  // Queue write side
  typedef struct packed {
    logic    push;
    q_item_t data;
  } q_wr_t;

  // Queue read side
  typedef struct packed {
    logic    valid;
    q_item_t data;
  } q_rd_t;

  // Configuration register set
  typedef struct packed {
    logic [15:0] idle_timeout;
    logic [15:0] release_timeout;
    logic [7:0]  hysteresis;
    logic [14:0] run_speed;
  } cfg_t;

endpackage

>>> rtl/sjs_front.sv
// ----------------------------------------------------------------------------
// sjs_front
// Accepts passes, classifies the output level and queues the classified pass.
// ----------------------------------------------------------------------------
module sjs_front import sjs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     q_full,
  input  logic [7:0] hysteresis,
  output q_wr_t    q_wr
);

  logic [1:0] level_class_r;
  logic [1:0] level_class_nxt;
  logic [1:0] class_new;
  logic       accept;

  logic signed [11:0] sup_s;
  logic signed [11:0] out_s;
  logic signed [11:0] quarter_s;
  logic signed [11:0] hyst_s;
  logic signed [11:0] lo_up;
  logic signed [11:0] lo_dn;
  logic signed [11:0] hi_up;
  logic signed [11:0] hi_dn;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Thresholds around supply/4 and supply - supply/4
  always_comb begin
    sup_s     = $signed({2'b00, in_data.supply_level});
    out_s     = $signed({2'b00, in_data.output_level});
    quarter_s = $signed({4'b0000, in_data.supply_level[9:2]});
    hyst_s    = $signed({4'b0000, hysteresis});
    lo_up     = quarter_s + hyst_s;
    lo_dn     = quarter_s - hyst_s;
    hi_up     = sup_s - quarter_s + hyst_s;
    hi_dn     = sup_s - quarter_s - hyst_s;
  end

  // Hysteresis classifier
  always_comb begin
    case (level_class_r)
      CL_LOW: begin
        if (out_s > lo_up) class_new = (out_s > hi_up) ? CL_HIGH : CL_OPEN;
        else               class_new = CL_LOW;
      end
      CL_HIGH: begin
        if (out_s < hi_dn) class_new = (out_s < lo_dn) ? CL_LOW : CL_OPEN;
        else               class_new = CL_HIGH;
      end
      default: begin
        if (out_s < lo_dn)      class_new = CL_LOW;
        else if (out_s > hi_up) class_new = CL_HIGH;
        else                    class_new = CL_OPEN;
      end
    endcase
    level_class_nxt = (in_data.sample_valid) ? class_new : level_class_r;
  end

  // Kept class
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_class_r <= CL_OPEN;
    end else if (accept) begin
      level_class_r <= level_class_nxt;
    end
  end

  // Queue entry
  always_comb begin
    q_wr.push                  = accept;
    q_wr.data.stop_pressed     = in_data.stop_pressed;
    q_wr.data.forward_pressed  = in_data.forward_pressed;
    q_wr.data.backward_pressed = in_data.backward_pressed;
    q_wr.data.front_limit      = in_data.front_limit;
    q_wr.data.rear_limit       = in_data.rear_limit;
    q_wr.data.elapsed_ticks    = in_data.elapsed_ticks;
    q_wr.data.level_class      = level_class_nxt;
  end

endmodule

>>> rtl/sjs_queue.sv
// ----------------------------------------------------------------------------
// sjs_queue
// Short first-word-fall-through queue between classifier and sequencer.
// ----------------------------------------------------------------------------
module sjs_queue import sjs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  q_wr_t q_wr,
  output logic  q_full,
  input  logic  q_pop,
  output q_rd_t q_rd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  q_item_t       entry_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          do_push;
  logic          do_pop;

  assign q_full     = (count_r == FULL);
  assign do_push    = q_wr.push && !q_full;
  assign do_pop     = q_pop && (count_r != '0);
  assign q_rd.valid = (count_r != '0);
  assign q_rd.data  = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop)      count_nxt = count_r + CW'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CW'(1);
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + AW'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + AW'(1);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= q_wr.data;
  end

endmodule

>>> rtl/sjs_back.sv
// ----------------------------------------------------------------------------
// sjs_back
// Jog sequencer: phase machine, countdown timer and registered result.
// ----------------------------------------------------------------------------
module sjs_back import sjs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_rd_t     q_rd,
  output logic      q_pop,
  input  cfg_t      cfg,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [2:0] {
    PH_SLEEP   = 3'd0,
    PH_WAIT    = 3'd1,
    PH_FWD     = 3'd2,
    PH_BWD     = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  phase_t      phase_r;
  phase_t      phase_nxt;
  logic [15:0] countdown_r;
  logic [15:0] countdown_nxt;
  logic [15:0] cd_mid;
  logic [1:0]  class_at_start_r;
  logic [1:0]  class_at_start_nxt;
  logic [2:0]  cmd;
  logic [15:0] speed;
  logic        opp;
  logic        lim;
  logic        out_valid_r;
  out_item_t   out_data_r;
  q_item_t     it;

  assign it        = q_rd.data;
  assign q_pop     = q_rd.valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next phase, command and countdown for the head request
  always_comb begin
    phase_nxt          = phase_r;
    cd_mid             = countdown_r;
    class_at_start_nxt = class_at_start_r;
    cmd                = CMD_NONE;
    speed              = '0;
    opp                = (phase_r == PH_FWD) ? it.backward_pressed : it.forward_pressed;
    lim                = (phase_r == PH_FWD) ? it.front_limit : it.rear_limit;
    unique case (phase_r)
      PH_SLEEP: begin
        if (it.forward_pressed || it.backward_pressed) begin
          cd_mid    = cfg.idle_timeout;
          phase_nxt = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (it.forward_pressed && !it.front_limit) begin
          class_at_start_nxt = it.level_class;
          cmd                = CMD_RUN_FWD;
          speed              = {1'b0, cfg.run_speed};
          phase_nxt          = PH_FWD;
        end else if (it.backward_pressed && !it.rear_limit) begin
          class_at_start_nxt = it.level_class;
          cmd                = CMD_RUN_BWD;
          speed              = 16'(16'd0 - {1'b0, cfg.run_speed});
          phase_nxt          = PH_BWD;
        end else if (countdown_r == '0) begin
          cmd       = CMD_SLEEP;
          phase_nxt = PH_SLEEP;
        end
      end
      PH_FWD, PH_BWD: begin
        if (it.stop_pressed || opp || lim || (it.level_class != class_at_start_r)) begin
          cmd       = CMD_STOP;
          cd_mid    = cfg.release_timeout;
          phase_nxt = PH_RELEASE;
        end
      end
      PH_RELEASE: begin
        if (!it.stop_pressed && !it.forward_pressed && !it.backward_pressed &&
            (countdown_r == '0)) begin
          cd_mid    = cfg.idle_timeout;
          phase_nxt = PH_WAIT;
        end
      end
      default: phase_nxt = PH_WAIT;
    endcase
    // Tick countdown, saturating at zero
    countdown_nxt = (cd_mid > {8'd0, it.elapsed_ticks}) ?
                    (cd_mid - {8'd0, it.elapsed_ticks}) : '0;
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_SLEEP;
      countdown_r      <= '0;
      class_at_start_r <= CL_OPEN;
    end else if (q_pop) begin
      phase_r          <= phase_nxt;
      countdown_r      <= countdown_nxt;
      class_at_start_r <= class_at_start_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r.motor_command  <= cmd;
      out_data_r.drive_speed    <= $signed(speed);
      out_data_r.sequence_state <= phase_nxt;
      out_data_r.analog_class   <= it.level_class;
      out_data_r.fault_led      <= (it.level_class != CL_OPEN);
    end
  end

endmodule

>>> rtl/stepper_jog_sequencer.sv
// ----------------------------------------------------------------------------
// stepper_jog_sequencer
// Jog controller for a stepper drive: analog class tracking and run/stop/sleep
// sequencing, one result per control pass.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_item_t   (one control pass)
//  out_    | output    | out_valid/out_stall| out_item_t  (one result)
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A pass is classified in the cycle it is accepted and queued; the sequencer
// takes one pass per cycle from the queue while no result is held by out_stall,
// so one pass per cycle is sustained; results are registered behind the queue.
// in_stall rises only when the queue is full; the queue absorbs out_stall.
// Synchronous reset clears phase, countdown, classes and the queue, and
// loads the register defaults. Configuration is always ready.
// ----------------------------------------------------------------------------
module stepper_jog_sequencer import sjs_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t  cfg_r;
  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_timeout    <= IDLE_TIMEOUT_RST;
      cfg_r.release_timeout <= RELEASE_TIMEOUT_RST;
      cfg_r.hysteresis      <= HYSTERESIS_RST;
      cfg_r.run_speed       <= RUN_SPEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IDLE_TIMEOUT:    cfg_r.idle_timeout    <= cfg_data;
        REG_RELEASE_TIMEOUT: cfg_r.release_timeout <= cfg_data;
        REG_HYSTERESIS:      cfg_r.hysteresis      <= cfg_data[7:0];
        REG_RUN_SPEED:       cfg_r.run_speed       <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  sjs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_full     (q_full),
    .hysteresis (cfg_r.hysteresis),
    .q_wr       (q_wr)
  );

  sjs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_rd   (q_rd)
  );

  sjs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rd      (q_rd),
    .q_pop     (q_pop),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Fault LED follows the reported class
  a_fault_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.fault_led == (out_data.analog_class != CL_OPEN)))
    else $error("fault_led does not match analog_class");

  // Only run commands carry a speed
  a_speed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.motor_command != CMD_RUN_FWD) &&
     (out_data.motor_command != CMD_RUN_BWD)) |-> (out_data.drive_speed == '0))
    else $error("nonzero drive_speed without a run command");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> !out_valid)
    else $error("result present right after reset");

  // The queue only fills while results back up
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (in_stall && !$past(in_stall)) |-> $past(q_rd.valid && !q_pop))
    else $error("input stalled without a backed-up queue");

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stepper jog sequencer: a queue of control passes
// (directed wake/run/stop/sleep sequences, then jog sequences with random
// content and some noise) feeds a clocked driver, a clocked monitor compares
// every result with the one predicted at acceptance, under random idling,
// random output stall and a long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import sjs_pkg::*;

  localparam int HOLD_CYCLES = 80;    // long output hold-off
  localparam int DRAIN_CYCLES = 8;    // result is registered behind the queue
  localparam int IDLE_LIMIT = 2000;   // cycles with no handshake before giving up
  localparam int PHASE_PASSES = 100;

  typedef enum logic [2:0] {
    PH_SLEEP   = 3'd0,
    PH_WAIT    = 3'd1,
    PH_FWD     = 3'd2,
    PH_BWD     = 3'd3,
    PH_RELEASE = 3'd4
  } jog_phase_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Predictor state and its copy of the registers
  cfg_t        pred_cfg;
  jog_phase_e  jog_phase = PH_SLEEP;
  logic [15:0] timeout_left = '0;
  logic [1:0]  cls_now = CL_OPEN;
  logic [1:0]  cls_at_start = CL_OPEN;

  in_item_t    passes_to_send[$];
  out_item_t   pass_results[$];
  int          passes_queued = 0;
  int          passes_taken = 0;
  int          fail_count = 0;
  int          idle_cycles = 0;
  int          hold_asks = 0;

  stepper_jog_sequencer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Output class with hysteresis around supply/4 and supply - supply/4
  function automatic logic [1:0] classify_level(logic [1:0] prev, int sup, int lvl);
    int t, h, lo_up, lo_dn, hi_up, hi_dn;
    t = sup / 4;
    h = int'(pred_cfg.hysteresis);
    lo_up = t + h;
    lo_dn = t - h;
    hi_up = sup - t + h;
    hi_dn = sup - t - h;
    if (prev == CL_LOW) return (lvl > lo_up) ? ((lvl > hi_up) ? CL_HIGH : CL_OPEN) : CL_LOW;
    if (prev == CL_HIGH) return (lvl < hi_dn) ? ((lvl < lo_dn) ? CL_LOW : CL_OPEN) : CL_HIGH;
    // open, or an unused code
    if (lvl < lo_dn) return CL_LOW;
    if (lvl > hi_up) return CL_HIGH;
    return CL_OPEN;
  endfunction

  // One control pass: classify, sequence, then run down the timer
  function automatic out_item_t jog_step(in_item_t p);
    out_item_t r;
    logic      opp, lim;
    r = '0;
    r.motor_command = CMD_NONE;
    if (p.sample_valid)
      cls_now = classify_level(cls_now, int'(p.supply_level), int'(p.output_level));
    case (jog_phase)
      PH_SLEEP: begin
        if (p.forward_pressed || p.backward_pressed) begin
          timeout_left = pred_cfg.idle_timeout;
          jog_phase = PH_WAIT;
        end
      end
      PH_WAIT: begin
        // forward wins when both buttons are down
        if (p.forward_pressed && !p.front_limit) begin
          cls_at_start = cls_now;
          r.motor_command = CMD_RUN_FWD;
          r.drive_speed = $signed({1'b0, pred_cfg.run_speed});
          jog_phase = PH_FWD;
        end else if (p.backward_pressed && !p.rear_limit) begin
          cls_at_start = cls_now;
          r.motor_command = CMD_RUN_BWD;
          r.drive_speed = -$signed({1'b0, pred_cfg.run_speed});
          jog_phase = PH_BWD;
        end else if (timeout_left == 16'd0) begin
          r.motor_command = CMD_SLEEP;
          jog_phase = PH_SLEEP;
        end
      end
      PH_FWD, PH_BWD: begin
        opp = (jog_phase == PH_FWD) ? p.backward_pressed : p.forward_pressed;
        lim = (jog_phase == PH_FWD) ? p.front_limit : p.rear_limit;
        if (p.stop_pressed || opp || lim || cls_now != cls_at_start) begin
          r.motor_command = CMD_STOP;
          timeout_left = pred_cfg.release_timeout;
          jog_phase = PH_RELEASE;
        end
      end
      PH_RELEASE: begin
        if (!p.stop_pressed && !p.forward_pressed && !p.backward_pressed &&
            timeout_left == 16'd0) begin
          timeout_left = pred_cfg.idle_timeout;
          jog_phase = PH_WAIT;
        end
      end
      default: jog_phase = PH_WAIT;
    endcase
    timeout_left = (timeout_left > p.elapsed_ticks) ? timeout_left - p.elapsed_ticks : 16'd0;
    r.sequence_state = jog_phase;
    r.analog_class = cls_now;
    r.fault_led = (cls_now != CL_OPEN);
    return r;
  endfunction

  // Gap length, mostly short, a few long, with stretches of none
  function automatic int idle_len(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Control pass with the given buttons; analog pair mostly mid-scale,
  // sometimes near a threshold, sometimes anywhere
  function automatic in_item_t make_pass(logic stp, logic fwd, logic bwd, logic front,
                                         logic rear, int ticks, int smp_pct, int wild);
    in_item_t p;
    int       s, v, h, r;
    p = '0;
    p.stop_pressed = stp;
    p.forward_pressed = fwd;
    p.backward_pressed = bwd;
    p.front_limit = front;
    p.rear_limit = rear;
    p.elapsed_ticks = ticks[7:0];
    p.sample_valid = (int'($urandom_range(0, 99)) < smp_pct);
    s = int'($urandom_range(0, 1023));
    h = int'(pred_cfg.hysteresis);
    r = int'($urandom_range(0, 99));
    if (r < wild)
      v = ($urandom_range(0, 1) ? s / 4 : s - s / 4) + int'($urandom_range(0, 2 * h + 6)) - (h + 3);
    else if (r < wild + 10)
      v = int'($urandom_range(0, 1023));
    else
      v = s / 2;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    p.supply_level = s[9:0];
    p.output_level = v[9:0];
    return p;
  endfunction

  task automatic queue_pass(in_item_t p);
    passes_to_send.push_back(p);
    passes_queued++;
  endtask

  // Analog step large enough to move the class
  function automatic in_item_t class_jump(in_item_t p);
    p.sample_valid = 1'b1;
    p.supply_level = 10'd1020;
    p.output_level = $urandom_range(0, 1) ? 10'd0 : 10'd1023;
    return p;
  endfunction

  // One random segment: mostly a jog (wake, run, stop, release), some
  // long idling, some noise
  task automatic queue_segment();
    int                          r, why;
    logic                        fw, bw;
    logic [63:0]                 rnd;
    logic [$bits(in_item_t)-1:0] raw;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      repeat ($urandom_range(1, 6)) begin
        rnd = {$urandom, $urandom};
        raw = rnd[$bits(in_item_t)-1:0];
        queue_pass(raw);
      end
    end else if (r < 25) begin
      repeat ($urandom_range(3, 12))
        queue_pass(make_pass(1'b0, 1'b0, 1'b0, 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), $urandom_range(128, 255), 40, 20));
    end else begin
      fw = 1'($urandom_range(0, 1));
      bw = !fw;
      repeat ($urandom_range(0, 2))
        queue_pass(make_pass(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, $urandom_range(0, 255), 40, 8));
      // press: wakes the sequencer, and a repeated press starts the run
      repeat ($urandom_range(1, 3))
        queue_pass(make_pass(1'b0, fw, bw, fw && ($urandom_range(0, 9) == 0),
                             bw && ($urandom_range(0, 9) == 0), $urandom_range(0, 20), 40, 8));
      repeat ($urandom_range(0, 4))
        queue_pass(make_pass(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, $urandom_range(0, 255), 40, 8));
      why = $urandom_range(0, 3);
      case (why)
        0: queue_pass(make_pass(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, $urandom_range(0, 255), 40, 8));
        1: queue_pass(make_pass(1'b0, bw, fw, 1'b0, 1'b0, $urandom_range(0, 255), 40, 8));
        2: queue_pass(make_pass(1'b0, 1'b0, 1'b0, fw, bw, $urandom_range(0, 255), 40, 8));
        default: queue_pass(class_jump(make_pass(1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                                 $urandom_range(0, 255), 40, 8)));
      endcase
      repeat ($urandom_range(1, 6))
        queue_pass(make_pass(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, $urandom_range(64, 255), 40, 8));
    end
  endtask

  // cfg_valid is held by the caller around a series of writes
  task automatic write_reg(logic [1:0] idx, logic [15:0] d);
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_IDLE_TIMEOUT:    pred_cfg.idle_timeout = d;
      REG_RELEASE_TIMEOUT: pred_cfg.release_timeout = d;
      REG_HYSTERESIS:      pred_cfg.hysteresis = d[7:0];
      REG_RUN_SPEED:       pred_cfg.run_speed = d[14:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [15:0] d_idle, logic [15:0] d_rel, logic [15:0] d_hyst,
                              logic [15:0] d_speed);
    cfg_valid <= 1'b1;
    write_reg(REG_IDLE_TIMEOUT, d_idle);
    write_reg(REG_RELEASE_TIMEOUT, d_rel);
    write_reg(REG_HYSTERESIS, d_hyst);
    write_reg(REG_RUN_SPEED, d_speed);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (passes_taken != passes_queued || pass_results.size() != 0) @(posedge clk);
  endtask

  // Driver: one request per handshake, random gaps between requests
  always @(posedge clk) begin
    int   send_gap, send_burst;
    logic nxt_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
      send_burst = 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        pass_results.push_back(jog_step(in_data));
        passes_taken++;
      end
      nxt_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (passes_to_send.size() != 0) begin
        in_data <= passes_to_send.pop_front();
        nxt_valid = 1'b1;
        send_gap = idle_len(send_burst);
      end
      in_valid <= nxt_valid;
    end
  end

  // Output stall: random gaps, plus a long hold-off on request
  always @(posedge clk) begin
    int stall_left, rcv_burst, hold_left, hold_seen;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      rcv_burst = 0;
      hold_left = 0;
      hold_seen = 0;
    end else begin
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (stall_left == 0) stall_left = idle_len(rcv_burst);
        if (stall_left > 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Monitor: each result against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pass_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("[%0t] result with nothing outstanding: cmd %0d speed %0d state %0d class %0d",
                   $time, out_data.motor_command, out_data.drive_speed,
                   out_data.sequence_state, out_data.analog_class);
      end else begin
        want = pass_results.pop_front();
        if (out_data.motor_command !== want.motor_command ||
            out_data.drive_speed !== want.drive_speed ||
            out_data.sequence_state !== want.sequence_state ||
            out_data.analog_class !== want.analog_class ||
            out_data.fault_led !== want.fault_led) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"[%0t] mismatch (expected/actual): cmd %0d/%0d speed %0d/%0d ",
                      "state %0d/%0d class %0d/%0d led %0d/%0d"}, $time,
                     want.motor_command, out_data.motor_command,
                     want.drive_speed, out_data.drive_speed,
                     want.sequence_state, out_data.sequence_state,
                     want.analog_class, out_data.analog_class,
                     want.fault_led, out_data.fault_led);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int ph, start;
    pred_cfg.idle_timeout = IDLE_TIMEOUT_RST;
    pred_cfg.release_timeout = RELEASE_TIMEOUT_RST;
    pred_cfg.hysteresis = HYSTERESIS_RST;
    pred_cfg.run_speed = RUN_SPEED_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, register defaults: field extremes, both buttons, class stop,
    // release timeout, limit stop, blocked starts
    queue_pass('0);
    queue_pass('1);
    queue_pass(make_pass(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 0, 0, 0));
    queue_pass(make_pass(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0, 0));
    queue_pass(class_jump(make_pass(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0, 0)));
    repeat (5) queue_pass(make_pass(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 255, 0, 0));
    queue_pass(make_pass(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 0, 0, 0));
    queue_pass(make_pass(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 0, 0, 0));
    repeat (4) queue_pass(make_pass(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 255, 0, 0));
    queue_pass(make_pass(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0, 0));
    queue_pass(make_pass(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 0, 0, 0));
    wait_drained();

    // Directed, zero timeouts, top hysteresis, zero run speed: sleep command,
    // stop button, opposite button
    program_regs(16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
    queue_pass(make_pass(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1, 0, 0));
    queue_pass(make_pass(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1, 0, 0));
    queue_pass(make_pass(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1, 0, 0));
    queue_pass(make_pass(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1, 0, 0));
    queue_pass(make_pass(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1, 0, 0));
    queue_pass(make_pass(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1, 0, 0));
    queue_pass(make_pass(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1, 0, 0));
    queue_pass(make_pass(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1, 0, 0));
    wait_drained();

    // Random phases, each under its own register setting
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        1: program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0001);
        2: program_regs(16'hFFFF, 16'hFFFF, 16'h00FF, 16'h7FFF);
        3: program_regs(16'h0001, 16'h0001, 16'h0001, 16'hFFFF);
        default: program_regs(16'($urandom_range(0, 1500)), 16'($urandom_range(0, 800)),
                              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      endcase
      start = passes_queued;
      while (passes_queued - start < PHASE_PASSES) queue_segment();
      // long receiver hold-off while requests keep coming
      if (ph == 4) hold_asks <= hold_asks + 1;
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pass_results.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
